/* design/nls_pkg.sv */
package nls_pkg;

  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_E_LO  = 8'h65;
  localparam logic [7:0] CHAR_E_UP  = 8'h45;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;

  localparam logic [30:0] ACC_MAX        = 31'h7FFF_FFFF;
  localparam logic [5:0]  FRAC_COUNT_MAX = 6'd63;

  // literal summary handed from the scanner to the integer stage
  typedef struct packed {
    logic        valid_res;
    logic        frac_type;
    logic        negative;
    logic [30:0] whole;
    logic [30:0] frac_val;
    logic [5:0]  frac_digits;
    logic        exp_negative;
    logic [30:0] exp_val;
    logic        exp_big;   // exponent of ten or more
    logic        ovf;
  } nls_snap_t;

  function automatic logic [29:0] pow10(input logic [3:0] idx);
    logic [29:0] p;
    case (idx)
      4'd0: p = 30'd1;
      4'd1: p = 30'd10;
      4'd2: p = 30'd100;
      4'd3: p = 30'd1000;
      4'd4: p = 30'd10000;
      4'd5: p = 30'd100000;
      4'd6: p = 30'd1000000;
      4'd7: p = 30'd10000000;
      4'd8: p = 30'd100000000;
      4'd9: p = 30'd1000000000;
      default: p = 30'd0;
    endcase
    return p;
  endfunction

endpackage

/* design/nls_scanner.sv */
module nls_scanner (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_char,
  input  logic                  in_last,
  output logic                  snap_valid,
  input  logic                  snap_ready,
  output nls_pkg::nls_snap_t    snap
);

  logic       in_full;
  logic [7:0] in_char_q;
  logic       in_last_q;

  logic        at_first_char;
  logic        sign_minus;
  logic        seen_point;
  logic        seen_exponent;
  logic        awaiting_exp_sign;
  logic        exp_minus;
  logic [2:0]  part_has_digit;
  logic        error_seen;
  logic        overflow_seen;
  logic [30:0] acc_whole;
  logic [30:0] acc_frac;
  logic [30:0] acc_exp;
  logic [5:0]  fraction_count;

  logic        sign_minus_next;
  logic        seen_point_next;
  logic        seen_exponent_next;
  logic        awaiting_exp_sign_next;
  logic        exp_minus_next;
  logic [2:0]  part_has_digit_next;
  logic        error_seen_next;
  logic        overflow_seen_next;
  logic [30:0] acc_whole_next;
  logic [30:0] acc_frac_next;
  logic [30:0] acc_exp_next;
  logic [5:0]  fraction_count_next;

  logic        snap_load;
  logic        fire;
  logic        is_digit;
  logic [3:0]  digit;
  logic [30:0] acc_cur;
  logic [34:0] acc_prod;
  logic [30:0] acc_new;
  logic        acc_sat;
  logic        lit_ok;
  nls_pkg::nls_snap_t snap_next;

  assign snap_load = !snap_valid || snap_ready;
  assign fire      = in_full && (!in_last_q || snap_load);
  assign in_ready  = !in_full || fire;

  assign is_digit = (in_char_q >= nls_pkg::CHAR_ZERO) && (in_char_q <= nls_pkg::CHAR_NINE);
  assign digit    = 4'(in_char_q - nls_pkg::CHAR_ZERO);

  always_comb begin
    if (seen_exponent) begin
      acc_cur = acc_exp;
    end else if (seen_point) begin
      acc_cur = acc_frac;
    end else begin
      acc_cur = acc_whole;
    end
  end

  // acc*10 + digit
  assign acc_prod = {1'b0, acc_cur, 3'b000} + {3'b000, acc_cur, 1'b0} + {31'd0, digit};
  assign acc_sat  = acc_prod > {4'd0, nls_pkg::ACC_MAX};
  assign acc_new  = acc_sat ? nls_pkg::ACC_MAX : acc_prod[30:0];

  always_comb begin
    sign_minus_next        = sign_minus;
    seen_point_next        = seen_point;
    seen_exponent_next     = seen_exponent;
    awaiting_exp_sign_next = awaiting_exp_sign;
    exp_minus_next         = exp_minus;
    part_has_digit_next    = part_has_digit;
    error_seen_next        = error_seen;
    overflow_seen_next     = overflow_seen;
    acc_whole_next         = acc_whole;
    acc_frac_next          = acc_frac;
    acc_exp_next           = acc_exp;
    fraction_count_next    = fraction_count;
    if (!error_seen) begin
      if (is_digit) begin
        if (acc_sat) begin
          overflow_seen_next = 1'b1;
        end
        if (seen_exponent) begin
          acc_exp_next           = acc_new;
          part_has_digit_next[2] = 1'b1;
        end else if (seen_point) begin
          acc_frac_next          = acc_new;
          part_has_digit_next[1] = 1'b1;
          if (fraction_count != nls_pkg::FRAC_COUNT_MAX) begin
            fraction_count_next = fraction_count + 6'd1;
          end
        end else begin
          acc_whole_next         = acc_new;
          part_has_digit_next[0] = 1'b1;
        end
        awaiting_exp_sign_next = 1'b0;
      end else if (in_char_q == nls_pkg::CHAR_MINUS && at_first_char) begin
        sign_minus_next = 1'b1;
      end else if (in_char_q == nls_pkg::CHAR_PLUS && at_first_char) begin
        sign_minus_next = 1'b0;
      end else if (awaiting_exp_sign) begin
        if (in_char_q == nls_pkg::CHAR_PLUS) begin
          exp_minus_next = 1'b0;
        end else if (in_char_q == nls_pkg::CHAR_MINUS) begin
          exp_minus_next = 1'b1;
        end else begin
          error_seen_next = 1'b1;
        end
        awaiting_exp_sign_next = 1'b0;
      end else if (in_char_q == nls_pkg::CHAR_POINT) begin
        if (seen_point || seen_exponent) begin
          error_seen_next = 1'b1;
        end else begin
          seen_point_next = 1'b1;
        end
      end else if (in_char_q == nls_pkg::CHAR_E_LO || in_char_q == nls_pkg::CHAR_E_UP) begin
        if (seen_exponent) begin
          error_seen_next = 1'b1;
        end else begin
          seen_exponent_next     = 1'b1;
          awaiting_exp_sign_next = 1'b1;
        end
      end else begin
        error_seen_next = 1'b1;
      end
    end
  end

  assign lit_ok = !error_seen_next && part_has_digit_next[0]
               && (!seen_point_next || part_has_digit_next[1])
               && (!seen_exponent_next || part_has_digit_next[2]);

  always_comb begin
    snap_next = '0;
    if (lit_ok) begin
      snap_next.valid_res    = 1'b1;
      snap_next.frac_type    = seen_point_next || (seen_exponent_next && exp_minus_next);
      snap_next.negative     = sign_minus_next;
      snap_next.whole        = acc_whole_next;
      snap_next.frac_val     = acc_frac_next;
      snap_next.frac_digits  = fraction_count_next;
      snap_next.exp_negative = exp_minus_next;
      snap_next.exp_val      = acc_exp_next;
      snap_next.exp_big      = (|acc_exp_next[30:4]) || (acc_exp_next[3:0] >= 4'd10);
      snap_next.ovf          = overflow_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_char_q <= in_char;
      in_last_q <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && in_last_q)) begin
      at_first_char     <= 1'b1;
      sign_minus        <= 1'b0;
      seen_point        <= 1'b0;
      seen_exponent     <= 1'b0;
      awaiting_exp_sign <= 1'b0;
      exp_minus         <= 1'b0;
      part_has_digit    <= '0;
      error_seen        <= 1'b0;
      overflow_seen     <= 1'b0;
      acc_whole         <= '0;
      acc_frac          <= '0;
      acc_exp           <= '0;
      fraction_count    <= '0;
    end else if (fire) begin
      at_first_char     <= 1'b0;
      sign_minus        <= sign_minus_next;
      seen_point        <= seen_point_next;
      seen_exponent     <= seen_exponent_next;
      awaiting_exp_sign <= awaiting_exp_sign_next;
      exp_minus         <= exp_minus_next;
      part_has_digit    <= part_has_digit_next;
      error_seen        <= error_seen_next;
      overflow_seen     <= overflow_seen_next;
      acc_whole         <= acc_whole_next;
      acc_frac          <= acc_frac_next;
      acc_exp           <= acc_exp_next;
      fraction_count    <= fraction_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (snap_load) begin
      snap_valid <= fire && in_last_q;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_last_q) begin
      snap <= snap_next;
    end
  end

  a_frac_digit_needs_point: assert property (@(posedge clk) disable iff (rst)
    (part_has_digit[1] || fraction_count != 6'd0) |-> seen_point)
    else $error("fraction digits without a point");

  a_exp_digit_needs_marker: assert property (@(posedge clk) disable iff (rst)
    (part_has_digit[2] || awaiting_exp_sign) |-> seen_exponent)
    else $error("exponent state without exponent marker");

  a_snap_only_on_last: assert property (@(posedge clk) disable iff (rst)
    (snap_valid && !$past(snap_valid)) |-> $past(in_last_q))
    else $error("literal summary without a last character");

endmodule

/* design/nls_int_stage.sv */
module nls_int_stage #(
  parameter int VALUE_WIDTH = nls_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                snap_valid,
  output logic                snap_ready,
  input  nls_pkg::nls_snap_t  snap,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [135:0]        m_tdata,
  output logic                m_tuser
);

  localparam int EFF_W = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
  localparam logic [31:0] LIMIT_NEG = 32'(64'd1 << (EFF_W - 1));
  localparam logic [31:0] LIMIT_POS = 32'((64'd1 << (EFF_W - 1)) - 64'd1);

  logic [29:0] scale;
  logic [31:0] limit;
  logic [60:0] prod;
  logic        sat;
  logic [31:0] mag;
  logic [31:0] ival;
  logic        ovf;

  assign snap_ready = !m_tvalid || m_tready;

  assign scale = nls_pkg::pow10(snap.exp_val[3:0]);
  assign limit = snap.negative ? LIMIT_NEG : LIMIT_POS;
  assign prod  = snap.whole * scale;
  assign sat   = (snap.whole != 31'd0) && (snap.exp_big || prod > {29'd0, limit});
  assign mag   = sat ? limit : prod[31:0];

  always_comb begin
    ival = '0;
    ovf  = snap.ovf;
    if (snap.valid_res && !snap.frac_type) begin
      ival = snap.negative ? (32'd0 - mag) : mag;
      ovf  = snap.ovf || sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (snap_ready) begin
      m_tvalid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) begin
      m_tdata <= {1'b0, ovf, ival, snap.exp_val, snap.exp_negative, snap.frac_digits,
                  snap.frac_val, snap.whole, snap.negative, snap.valid_res};
      m_tuser <= snap.frac_type;
    end
  end

  a_frac_no_int: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[133:102] == 32'd0))
    else $error("fractional literal with nonzero integer value");

  a_invalid_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[135:1] == '0 && !m_tuser))
    else $error("invalid literal with nonzero fields");

  a_int_sign: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[133]) |-> m_tdata[1])
    else $error("negative integer value for a positive literal");

endmodule

/* design/number_literal_scanner_core.sv */
// channel  dir  signals                          transaction
// s_       in   s_tvalid s_tready s_tdata s_tlast one character of a literal
// m_       out  m_tvalid m_tready m_tdata m_tuser one scan result per literal
//
// One character is taken per cycle while no last character is held; m_tvalid rises
// once the last character has passed the input, summary and result registers.
// The integer path is one 31x30 multiply by a power-of-ten table entry.
// rst is synchronous and returns the scanner to the start of a literal.
// m_tready low holds the result; characters still flow, and a last character
// waits in the input register while the one-deep summary register is full.
module number_literal_scanner_core #(
  parameter int VALUE_WIDTH = nls_pkg::VALUE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // char_code[7:0]
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // valid_res[0], negative[1], whole_value[32:2], fraction_value[63:33],
  // fraction_digits[69:64], exponent_negative[70], exponent_value[101:71],
  // int_value[133:102], overflow[134], zero pad[135]
  output logic [135:0] m_tdata,
  output logic         m_tuser    // is_fractional_type[0]
);

  logic               snap_valid;
  logic               snap_ready;
  nls_pkg::nls_snap_t snap;

  nls_scanner u_scanner (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_char    (s_tdata),
    .in_last    (s_tlast),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  nls_int_stage #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_int_stage (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule
